[src/lcp_pkg.sv]
// Shared types, codes and name tables for the load command layout parser.
package lcp_pkg;

  localparam logic [31:0] IMAGE_MAGIC    = 32'hfeed_facf;
  localparam logic [31:0] KIND_SEGMENT   = 32'h0000_0019;
  localparam logic [31:0] KIND_SIGNATURE = 32'h0000_001d;
  localparam int unsigned HEADER_BYTES   = 32;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ST_SHORT_CMDS  = 3'd2;
  localparam logic [2:0] ST_MALFORMED   = 3'd3;
  localparam logic [2:0] ST_NO_LINKEDIT = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] linkedit_cmd_offset;
    logic [63:0] linkedit_vm_address;
    logic [63:0] linkedit_file_offset;
    logic        text_found;
    logic [31:0] text_cmd_offset;
    logic [63:0] text_file_size;
    logic        sig_found;
    logic [31:0] sig_cmd_offset;
    logic [31:0] sig_data_offset;
  } result_t;

  // "__LINKEDIT" followed by NUL, indexed by offset within the command (8..18)
  function automatic logic [7:0] le_name_byte(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd8:    c = 8'h5f;
      6'd9:    c = 8'h5f;
      6'd10:   c = 8'h4c;
      6'd11:   c = 8'h49;
      6'd12:   c = 8'h4e;
      6'd13:   c = 8'h4b;
      6'd14:   c = 8'h45;
      6'd15:   c = 8'h44;
      6'd16:   c = 8'h49;
      6'd17:   c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "__TEXT" followed by NUL, indexed by offset within the command (8..14)
  function automatic logic [7:0] tx_name_byte(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd8:    c = 8'h5f;
      6'd9:    c = 8'h5f;
      6'd10:   c = 8'h54;
      6'd11:   c = 8'h45;
      6'd12:   c = 8'h58;
      6'd13:   c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[src/lcp_if.sv]
// Valid/ready channel interfaces for image bytes and parse results.
interface lcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       final_byte;

  modport source (output valid, image_byte, final_byte, input ready);
  modport sink   (input valid, image_byte, final_byte, output ready);
endinterface

interface lcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] linkedit_cmd_offset;
  logic [63:0] linkedit_vm_address;
  logic [63:0] linkedit_file_offset;
  logic        text_found;
  logic [31:0] text_cmd_offset;
  logic [63:0] text_file_size;
  logic        sig_found;
  logic [31:0] sig_cmd_offset;
  logic [31:0] sig_data_offset;

  modport source (output valid, status, linkedit_cmd_offset, linkedit_vm_address,
                  linkedit_file_offset, text_found, text_cmd_offset, text_file_size,
                  sig_found, sig_cmd_offset, sig_data_offset, input ready);
  modport sink   (input valid, status, linkedit_cmd_offset, linkedit_vm_address,
                  linkedit_file_offset, text_found, text_cmd_offset, text_file_size,
                  sig_found, sig_cmd_offset, sig_data_offset, output ready);
endinterface

[src/lcp_walker.sv]
// Per-byte header and load command walker: parse state, captures and result decision.
module lcp_walker #(
  parameter int POSITION_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        image_byte,
  input  logic              final_byte,
  output logic              res_valid,
  output lcp_pkg::result_t  res
);
  import lcp_pkg::*;

  localparam int CW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_COMMANDS = 2'd1;
  localparam logic [1:0] PH_SKIP     = 2'd2;

  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [1:0]               phase, phase_next;
  logic [31:0]              total, total_next;
  logic [31:0]              done, done_next;
  logic [POSITION_BITS-1:0] cstart, cstart_next;
  logic                     kind_seg, kind_seg_next;
  logic                     kind_sig, kind_sig_next;
  logic [31:0]              last, last_next;     // command size minus one
  logic [31:0]              rel, rel_next;       // offset within current command
  logic [55:0]              gather, gather_next;
  logic                     nm_le, nm_le_next;
  logic                     nm_tx, nm_tx_next;
  logic                     le_seen, le_seen_next;
  logic [31:0]              le_off, le_off_next;
  logic [63:0]              le_vm, le_vm_next;
  logic [63:0]              le_fo, le_fo_next;
  logic                     tx_found, tx_found_next;
  logic [31:0]              tx_off, tx_off_next;
  logic [63:0]              tx_size, tx_size_next;
  logic                     sg_found, sg_found_next;
  logic [31:0]              sg_off, sg_off_next;
  logic [31:0]              sg_data, sg_data_next;

  logic [4:0]  hdr_idx;
  logic        hdr_in;
  logic [31:0] hdr_word;
  logic [5:0]  rel_lo;
  logic        rel_in64;
  logic        rel_lt8;
  logic [63:0] cmd_word;
  logic [31:0] new_kind;
  logic [31:0] new_size;
  logic [31:0] size_m1;
  logic        size_bad;
  logic [31:0] done_inc;
  logic        ended;
  logic [2:0]  status_c;

  assign hdr_idx  = pos[4:0];
  assign hdr_in   = (pos[POSITION_BITS-1:5] == '0);
  assign hdr_word = {image_byte, gather[23:0]};
  assign rel_lo   = rel[5:0];
  assign rel_in64 = (rel[31:6] == '0);
  assign rel_lt8  = (rel[31:3] == '0);
  assign cmd_word = {image_byte, gather};
  assign new_kind = cmd_word[31:0];
  assign new_size = cmd_word[63:32];
  assign size_m1  = new_size - 32'd1;
  // the command must end at or below the top of the position space
  assign size_bad = (new_size < 32'd8) || (CW'(size_m1) > CW'(~cstart));
  assign done_inc = done + 32'd1;

  always_comb begin
    pos_next      = pos + 1'b1;
    phase_next    = phase;
    total_next    = total;
    done_next     = done;
    cstart_next   = cstart;
    kind_seg_next = kind_seg;
    kind_sig_next = kind_sig;
    last_next     = last;
    rel_next      = rel;
    gather_next   = gather;
    nm_le_next    = nm_le;
    nm_tx_next    = nm_tx;
    le_seen_next  = le_seen;
    le_off_next   = le_off;
    le_vm_next    = le_vm;
    le_fo_next    = le_fo;
    tx_found_next = tx_found;
    tx_off_next   = tx_off;
    tx_size_next  = tx_size;
    sg_found_next = sg_found;
    sg_off_next   = sg_off;
    sg_data_next  = sg_data;
    ended         = 1'b0;
    res_valid     = 1'b0;
    status_c      = ST_OK;

    unique case (phase)
      PH_HEADER: begin
        if (hdr_in && hdr_idx < 5'd4) begin
          gather_next[{hdr_idx[1:0], 3'b000} +: 8] = image_byte;
        end else if (hdr_in && hdr_idx >= 5'd16 && hdr_idx < 5'd20) begin
          if (hdr_idx == 5'd16) begin
            gather_next = '0;
          end
          gather_next[{hdr_idx[1:0], 3'b000} +: 8] = image_byte;
          if (hdr_idx == 5'd19) begin
            total_next = hdr_word;
          end
        end

        if (hdr_in && hdr_idx == 5'd3 && hdr_word != IMAGE_MAGIC) begin
          res_valid = 1'b1;
          status_c  = ST_BAD_MAGIC;
        end else if (hdr_in && hdr_idx == 5'd31) begin
          if (total == '0) begin
            res_valid = 1'b1;
            status_c  = le_seen ? ST_OK : ST_NO_LINKEDIT;
          end else begin
            phase_next  = PH_COMMANDS;
            cstart_next = POSITION_BITS'(HEADER_BYTES);
            done_next   = '0;
            rel_next    = '0;
            if (final_byte) begin
              res_valid = 1'b1;
              status_c  = ST_SHORT_CMDS;
            end
          end
        end else if (final_byte) begin
          res_valid = 1'b1;
          status_c  = ST_BAD_MAGIC;
        end
      end

      PH_COMMANDS: begin
        rel_next = rel + 32'd1;
        if (rel == '0) begin
          gather_next = '0;
          nm_le_next  = 1'b1;
          nm_tx_next  = 1'b1;
        end

        if (rel_lt8) begin
          if (rel[2:0] != 3'd7) begin
            gather_next[{rel[2:0], 3'b000} +: 8] = image_byte;
          end else begin
            kind_seg_next = (new_kind == KIND_SEGMENT);
            kind_sig_next = (new_kind == KIND_SIGNATURE);
            last_next     = size_m1;
            if (size_bad) begin
              res_valid = 1'b1;
              status_c  = ST_MALFORMED;
            end else if (new_kind == KIND_SIGNATURE) begin
              sg_found_next = 1'b1;
              sg_off_next   = 32'(cstart);
              sg_data_next  = '0;
            end
          end
        end else if (kind_seg) begin
          if (rel_in64 && rel_lo <= 6'd18 && image_byte != le_name_byte(rel_lo)) begin
            nm_le_next = 1'b0;
          end
          if (rel_in64 && rel_lo <= 6'd14 && image_byte != tx_name_byte(rel_lo)) begin
            nm_tx_next = 1'b0;
          end
          if (rel_in64 && rel_lo == 6'd14 && nm_tx_next) begin
            tx_found_next = 1'b1;
            tx_off_next   = 32'(cstart);
            tx_size_next  = '0;
          end
          if (rel_in64 && rel_lo == 6'd18 && nm_le_next) begin
            le_seen_next = 1'b1;
            le_off_next  = 32'(cstart);
            le_vm_next   = '0;
            le_fo_next   = '0;
          end
          if (rel_in64 && rel_lo[5:3] == 3'd3 && nm_le) begin
            le_vm_next[{rel_lo[2:0], 3'b000} +: 8] = image_byte;
          end
          if (rel_in64 && rel_lo[5:3] == 3'd5 && nm_le) begin
            le_fo_next[{rel_lo[2:0], 3'b000} +: 8] = image_byte;
          end
          if (rel_in64 && rel_lo[5:3] == 3'd6 && nm_tx) begin
            tx_size_next[{rel_lo[2:0], 3'b000} +: 8] = image_byte;
          end
        end else if (kind_sig && rel_in64 && rel_lo < 6'd12) begin
          sg_data_next[{rel_lo[1:0], 3'b000} +: 8] = image_byte;
        end

        // end of command: size byte itself for an 8-byte command
        if (!res_valid) begin
          if (rel_lt8) begin
            ended = (rel[2:0] == 3'd7) && (size_m1 == 32'd7);
          end else begin
            ended = (rel == last);
          end
        end

        if (ended) begin
          done_next = done_inc;
          rel_next  = '0;
          if (done_inc == total) begin
            res_valid = 1'b1;
            status_c  = le_seen_next ? ST_OK : ST_NO_LINKEDIT;
          end else begin
            cstart_next = pos + 1'b1;
          end
        end

        if (!res_valid && final_byte) begin
          res_valid = 1'b1;
          status_c  = (ended || (rel_lt8 && rel[2:0] != 3'd7)) ? ST_SHORT_CMDS
                                                                : ST_MALFORMED;
        end
      end

      default: begin
      end
    endcase

    if (res_valid) begin
      phase_next = PH_SKIP;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status_c;
    if (status_c == ST_OK) begin
      res.linkedit_cmd_offset  = le_off_next;
      res.linkedit_vm_address  = le_vm_next;
      res.linkedit_file_offset = le_fo_next;
      res.text_found           = tx_found_next;
      res.text_cmd_offset      = tx_off_next;
      res.text_file_size       = tx_size_next;
      res.sig_found            = sg_found_next;
      res.sig_cmd_offset       = sg_off_next;
      res.sig_data_offset      = sg_data_next;
    end
  end

  // final_byte returns the walker to its reset state for the next image
  always_ff @(posedge clk) begin
    if (rst || (step && final_byte)) begin
      pos      <= '0;
      phase    <= PH_HEADER;
      total    <= '0;
      done     <= '0;
      cstart   <= POSITION_BITS'(HEADER_BYTES);
      kind_seg <= 1'b0;
      kind_sig <= 1'b0;
      last     <= '0;
      rel      <= '0;
      gather   <= '0;
      nm_le    <= 1'b1;
      nm_tx    <= 1'b1;
      le_seen  <= 1'b0;
      le_off   <= '0;
      le_vm    <= '0;
      le_fo    <= '0;
      tx_found <= 1'b0;
      tx_off   <= '0;
      tx_size  <= '0;
      sg_found <= 1'b0;
      sg_off   <= '0;
      sg_data  <= '0;
    end else if (step) begin
      pos      <= pos_next;
      phase    <= phase_next;
      total    <= total_next;
      done     <= done_next;
      cstart   <= cstart_next;
      kind_seg <= kind_seg_next;
      kind_sig <= kind_sig_next;
      last     <= last_next;
      rel      <= rel_next;
      gather   <= gather_next;
      nm_le    <= nm_le_next;
      nm_tx    <= nm_tx_next;
      le_seen  <= le_seen_next;
      le_off   <= le_off_next;
      le_vm    <= le_vm_next;
      le_fo    <= le_fo_next;
      tx_found <= tx_found_next;
      tx_off   <= tx_off_next;
      tx_size  <= tx_size_next;
      sg_found <= sg_found_next;
      sg_off   <= sg_off_next;
      sg_data  <= sg_data_next;
    end
  end

endmodule

[src/load_command_layout_parser.sv]
// Top level: input register, byte walker and result register of the load command parser.
// Result timing: a result is loaded into the result register when the byte that settles it
//   leaves the input register and steps the walker; walker update and result load share an edge.
// Throughput: one image byte per cycle; the input side stalls only while a byte is held
//   and a finished result is still waiting to be taken.
// Reset: rst (synchronous) clears all parse state; a byte with final_byte set also
//   returns the walker to its reset state for the next image.
module load_command_layout_parser #(
  parameter int POSITION_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  lcp_in_if.sink     byte_in,
  lcp_out_if.source  result_out
);
  import lcp_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_final;

  // result register
  logic       out_valid;
  result_t    out_res;

  logic       advance;
  logic       res_valid;
  result_t    res;

  // the held byte goes through the walker when the result slot can take a result
  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign byte_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte  <= byte_in.image_byte;
      in_final <= byte_in.final_byte;
    end
  end

  lcp_walker #(
    .POSITION_BITS(POSITION_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .image_byte (in_byte),
    .final_byte (in_final),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result transaction register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign result_out.valid                = out_valid;
  assign result_out.status               = out_res.status;
  assign result_out.linkedit_cmd_offset  = out_res.linkedit_cmd_offset;
  assign result_out.linkedit_vm_address  = out_res.linkedit_vm_address;
  assign result_out.linkedit_file_offset = out_res.linkedit_file_offset;
  assign result_out.text_found           = out_res.text_found;
  assign result_out.text_cmd_offset      = out_res.text_cmd_offset;
  assign result_out.text_file_size       = out_res.text_file_size;
  assign result_out.sig_found            = out_res.sig_found;
  assign result_out.sig_cmd_offset       = out_res.sig_cmd_offset;
  assign result_out.sig_data_offset      = out_res.sig_data_offset;

endmodule
